@@ rtl/ldsu_pkg.sv @@
package ldsu_pkg;

	// Default board counts
	localparam int FOUR_DIGIT_BOARDS_DEF  = 4;
	localparam int EIGHT_DIGIT_BOARDS_DEF = 3;

	// Input command kinds
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_LED   = 3'd1;
	localparam logic [2:0] CMD_ON    = 3'd2;
	localparam logic [2:0] CMD_OFF   = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Driver operations
	localparam logic [1:0] OP_DATA  = 2'd0;
	localparam logic [1:0] OP_ON    = 2'd1;
	localparam logic [1:0] OP_OFF   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Control byte fields
	localparam int         TYPE_POS    = 2;
	localparam int         HALF_POS    = 3;
	localparam int         SIZE_POS    = 4;
	localparam int         LED_VAL_POS = 5;
	localparam logic [7:0] LED_MASK    = 8'd28;
	localparam logic [7:0] LEVEL_MASK  = 8'd56;

	// What an accepted transaction turns into
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_WRITE4 = 2'd1,
		KIND_WRITE8 = 2'd2,
		KIND_SINGLE = 2'd3
	} kind_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic emit_load;
		logic single_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  scan_last;
		logic  eight;
		logic  mask_zero;
		logic  out_free;
	} dp_stat_t;

endpackage

@@ rtl/led_display_shadow_update.sv @@
// Channel | Handshake               | Payload
// in      | in_valid / in_stall     | command, ctrl_byte, data_bytes
// out     | out_valid / out_stall   | op, board, address, value, level, last
//
// Display write: the controller walks the shadow memory port one byte per
// cycle over the N bytes (N = 4 or 8), then an 8-digit board write emits
// one driver write per changed byte; a 4-digit board write updates the
// shadow only. Shadow entries read as zero after reset through
// per-entry valid flops; no clearing pass. A stalled output holds the
// controller in its emit or single state; the input is taken only when idle.
module led_display_shadow_update #(
	parameter int FOUR_DIGIT_BOARDS  = ldsu_pkg::FOUR_DIGIT_BOARDS_DEF,
	parameter int EIGHT_DIGIT_BOARDS = ldsu_pkg::EIGHT_DIGIT_BOARDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  ctrl_byte,
	input  logic [63:0] data_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  op,
	output logic [1:0]  board,
	output logic [3:0]  address,
	output logic [7:0]  value,
	output logic [2:0]  level,
	output logic        last
);
	import ldsu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer
	ldsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Shadow store, compare and output register
	ldsu_datapath #(
		.FOUR_DIGIT_BOARDS  (FOUR_DIGIT_BOARDS),
		.EIGHT_DIGIT_BOARDS (EIGHT_DIGIT_BOARDS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.command    (command),
		.ctrl_byte  (ctrl_byte),
		.data_bytes (data_bytes),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.op         (op),
		.board      (board),
		.address    (address),
		.value      (value),
		.level      (level),
		.last       (last)
	);

endmodule

@@ rtl/ldsu_ctrl.sv @@
module ldsu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ldsu_pkg::dp_stat_t stat,
	output ldsu_pkg::dp_cmd_t  cmd
);
	import ldsu_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_SETTLE = 5'b00100,
		ST_EMIT   = 5'b01000,
		ST_SINGLE = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					case (stat.kind)
						KIND_WRITE4: state_nxt = ST_SCAN;
						KIND_WRITE8: state_nxt = ST_SCAN;
						KIND_SINGLE: state_nxt = ST_SINGLE;
						default:     state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_last) begin
					state_nxt = ST_SETTLE;
				end
			end
			// last compare lands in the change mask here
			ST_SETTLE: begin
				state_nxt = stat.eight ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (stat.mask_zero) begin
					state_nxt = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.emit_load = 1'b1;
				end
			end
			ST_SINGLE: begin
				if (stat.out_free) begin
					cmd.single_load = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

@@ rtl/ldsu_datapath.sv @@
module ldsu_datapath #(
	parameter int FOUR_DIGIT_BOARDS  = ldsu_pkg::FOUR_DIGIT_BOARDS_DEF,
	parameter int EIGHT_DIGIT_BOARDS = ldsu_pkg::EIGHT_DIGIT_BOARDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ldsu_pkg::dp_cmd_t  cmd,
	output ldsu_pkg::dp_stat_t stat,
	input  logic [2:0]         command,
	input  logic [7:0]         ctrl_byte,
	input  logic [63:0]        data_bytes,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         op,
	output logic [1:0]         board,
	output logic [3:0]         address,
	output logic [7:0]         value,
	output logic [2:0]         level,
	output logic               last
);
	import ldsu_pkg::*;

	localparam int         DEPTH     = 4 * FOUR_DIGIT_BOARDS + 8 * EIGHT_DIGIT_BOARDS;
	localparam int         IDX_W     = $clog2(DEPTH);
	localparam int         FOUR_BASE = 4 * FOUR_DIGIT_BOARDS;
	localparam logic [2:0] FOUR_N    = 3'(FOUR_DIGIT_BOARDS);
	localparam logic [2:0] EIGHT_N   = 3'(EIGHT_DIGIT_BOARDS);

	// Transaction registers
	logic [2:0]       command_q;
	logic [7:0]       ctrl_q;
	logic [63:0]      data_q;
	logic             eight_q;
	logic             half_q;
	logic [2:0]       last_i_q;
	logic [IDX_W-1:0] base_q;
	logic [2:0]       i_q;
	logic [7:0]       mask_q;

	// Shadow store and read stage
	logic [7:0]       shadow_mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       rd_data_s1;
	logic             rd_valid_s1;
	logic             cmp_en_s1;
	logic [2:0]       cmp_i_s1;

	// Output register
	logic       out_vld_q;
	logic [1:0] op_q;
	logic [1:0] board_q;
	logic [3:0] address_q;
	logic [7:0] value_q;
	logic [2:0] level_q;
	logic       last_q;

	logic             in_eight;
	logic             in_size8;
	logic             in_range4;
	logic             in_range8;
	logic [IDX_W-1:0] in_base;
	kind_t            in_kind;
	logic [2:0]       scan_pos;
	logic [IDX_W-1:0] scan_idx;
	logic [7:0]       scan_byte;
	logic [7:0]       old_byte;
	logic [7:0]       cmp_byte;
	logic [2:0]       sel_i;
	logic             sel_found;
	logic [2:0]       sel_pos;
	logic             out_free;
	logic [1:0]       s_op;
	logic [3:0]       s_addr;
	logic [7:0]       s_val;
	logic [2:0]       s_lvl;

	// Decode of the incoming transaction
	assign in_eight  = ctrl_byte[TYPE_POS];
	assign in_size8  = ctrl_byte[SIZE_POS];
	assign in_range4 = ({1'b0, ctrl_byte[1:0]} < FOUR_N);
	assign in_range8 = ({1'b0, ctrl_byte[1:0]} < EIGHT_N);
	assign in_base   = in_eight ? IDX_W'(FOUR_BASE) + IDX_W'({ctrl_byte[1:0], 3'b000})
	                            : IDX_W'({ctrl_byte[1:0], 2'b00});

	always_comb begin
		case (command)
			CMD_WRITE: begin
				if (in_eight) begin
					in_kind = in_range8 ? KIND_WRITE8 : KIND_NONE;
				end else begin
					in_kind = in_range4 ? KIND_WRITE4 : KIND_NONE;
				end
			end
			CMD_LED:   in_kind = in_range8 ? KIND_SINGLE : KIND_NONE;
			CMD_ON:    in_kind = (in_eight && in_range8) ? KIND_SINGLE : KIND_NONE;
			CMD_OFF:   in_kind = (in_eight && in_range8) ? KIND_SINGLE : KIND_NONE;
			CMD_CLEAR: in_kind = (in_eight && in_range8) ? KIND_SINGLE : KIND_NONE;
			default:   in_kind = KIND_NONE;
		endcase
	end

	// Latch transaction; scan counter and change mask
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			command_q <= command;
			ctrl_q    <= ctrl_byte;
			data_q    <= data_bytes;
			eight_q   <= in_eight;
			half_q    <= in_eight && !in_size8 && ctrl_byte[HALF_POS];
			last_i_q  <= (in_eight && in_size8) ? 3'd7 : 3'd3;
			base_q    <= in_base;
			i_q       <= 3'd0;
			mask_q    <= 8'd0;
		end else begin
			if (cmd.scan) begin
				i_q <= i_q + 3'd1;
			end
			if (cmp_en_s1) begin
				mask_q[cmp_i_s1] <= (old_byte != cmp_byte);
			end else if (cmd.emit_load) begin
				mask_q[sel_i] <= 1'b0;
			end
		end
	end

	// Scan address: byte i lands at digit start + i
	assign scan_pos  = {half_q | i_q[2], i_q[1:0]};
	assign scan_idx  = base_q + IDX_W'(scan_pos);
	assign scan_byte = data_q[{i_q, 3'b000} +: 8];

	// Shadow read of old byte and write of new byte in the same cycle
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_data_s1             <= shadow_mem[scan_idx];
			shadow_mem[scan_idx]   <= scan_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			cmp_en_s1   <= 1'b0;
			cmp_i_s1    <= 3'd0;
		end else begin
			cmp_en_s1 <= cmd.scan;
			if (cmd.scan) begin
				rd_valid_s1        <= valid_q[scan_idx];
				valid_q[scan_idx]  <= 1'b1;
				cmp_i_s1           <= i_q;
			end
		end
	end

	// Never-written entries read as zero
	assign old_byte = rd_valid_s1 ? rd_data_s1 : 8'd0;
	assign cmp_byte = data_q[{cmp_i_s1, 3'b000} +: 8];

	// Lowest pending changed byte
	always_comb begin
		sel_i     = 3'd0;
		sel_found = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (mask_q[k] && !sel_found) begin
				sel_i     = 3'(k);
				sel_found = 1'b1;
			end
		end
	end

	assign sel_pos = {half_q | sel_i[2], sel_i[1:0]};

	// Fields of a single-command result
	always_comb begin
		s_op   = OP_CLEAR;
		s_addr = 4'd0;
		s_val  = 8'd0;
		s_lvl  = 3'd0;
		case (command_q)
			CMD_LED: begin
				s_op   = OP_DATA;
				s_addr = {3'((ctrl_q & LED_MASK) >> 2), 1'b1};
				s_val  = {7'd0, ctrl_q[LED_VAL_POS]};
			end
			CMD_ON: begin
				s_op  = OP_ON;
				s_lvl = 3'((ctrl_q & LEVEL_MASK) >> 3);
			end
			CMD_OFF:   s_op = OP_OFF;
			CMD_CLEAR: s_op = OP_CLEAR;
			default:   s_op = OP_CLEAR;
		endcase
	end

	// Output register
	assign out_free = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit_load || cmd.single_load) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			op_q      <= OP_DATA;
			board_q   <= ctrl_q[1:0];
			address_q <= {sel_pos, 1'b0};
			value_q   <= data_q[{sel_i, 3'b000} +: 8];
			level_q   <= 3'd0;
			last_q    <= ((mask_q & ~(8'd1 << sel_i)) == 8'd0);
		end else if (cmd.single_load) begin
			op_q      <= s_op;
			board_q   <= ctrl_q[1:0];
			address_q <= s_addr;
			value_q   <= s_val;
			level_q   <= s_lvl;
			last_q    <= 1'b1;
		end
	end

	assign out_valid = out_vld_q;
	assign op        = op_q;
	assign board     = board_q;
	assign address   = address_q;
	assign value     = value_q;
	assign level     = level_q;
	assign last      = last_q;

	// Status back to the controller
	assign stat.kind      = in_kind;
	assign stat.scan_last = (i_q == last_i_q);
	assign stat.eight     = eight_q;
	assign stat.mask_zero = (mask_q == 8'd0);
	assign stat.out_free  = out_free;

endmodule

@@ verif/led_display_shadow_update_test.sv @@
module led_display_shadow_update_test;
	import ldsu_pkg::*;

	localparam int NUM_FOUR     = FOUR_DIGIT_BOARDS_DEF;
	localparam int NUM_EIGHT    = EIGHT_DIGIT_BOARDS_DEF;
	localparam int MIRROR_DEPTH = 4 * NUM_FOUR + 8 * NUM_EIGHT;
	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES  = 80;
	localparam int TAIL_CYCLES  = 40;
	localparam int IDLE_PCT     = 37;
	localparam int REPORT_LIMIT = 10;

	// Command kinds the block must ignore
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	// One driver write as seen on the output channel
	typedef struct packed {
		logic [1:0] op;
		logic [1:0] board;
		logic [3:0] address;
		logic [7:0] value;
		logic [2:0] level;
		logic       last;
	} drv_write_t;

	// Directed stimulus row; typed rows carry their own expectation (none or one write)
	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  ctrl;
		logic [63:0] data;
		logic        typed;
		logic        has_write;
		drv_write_t  typed_w;
	} stim_row_t;

	localparam drv_write_t NO_WRITE = '0;
	localparam int NUM_ROWS = 24;

	stim_row_t directed_rows [NUM_ROWS] = '{
		// full write of zeros right after reset: nothing differs
		'{CMD_WRITE, 8'h14, 64'h0, 1'b1, 1'b0, NO_WRITE},
		// one changed byte on board 0
		'{CMD_WRITE, 8'h04, 64'hFF, 1'b1, 1'b1,
			'{OP_DATA, 2'd0, 4'd0, 8'hFF, 3'd0, 1'b1}},
		// all eight bytes change on the highest 8-digit board
		'{CMD_WRITE, 8'h16, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_WRITE},
		// second half back to zero
		'{CMD_WRITE, 8'h0E, 64'h0, 1'b0, 1'b0, NO_WRITE},
		// eight-byte write with the half bit set: half is ignored
		'{CMD_WRITE, 8'h1D, 64'h8000_0000_0000_0001, 1'b0, 1'b0, NO_WRITE},
		// 4-digit board: shadow only
		'{CMD_WRITE, 8'h03, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_WRITE},
		// 8-digit board index past the count
		'{CMD_WRITE, 8'h07, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, NO_WRITE},
		// led set extremes
		'{CMD_LED, 8'h3C, 64'h0, 1'b1, 1'b1,
			'{OP_DATA, 2'd0, 4'd15, 8'h01, 3'd0, 1'b1}},
		'{CMD_LED, 8'h01, 64'h0, 1'b1, 1'b1,
			'{OP_DATA, 2'd1, 4'd1, 8'h00, 3'd0, 1'b1}},
		'{CMD_LED, 8'hFF, 64'h0, 1'b1, 1'b0, NO_WRITE},
		// brightness extremes, then a 4-digit target
		'{CMD_ON, 8'h3C, 64'h0, 1'b1, 1'b1,
			'{OP_ON, 2'd0, 4'd0, 8'h00, 3'd7, 1'b1}},
		'{CMD_ON, 8'h06, 64'h0, 1'b1, 1'b1,
			'{OP_ON, 2'd2, 4'd0, 8'h00, 3'd0, 1'b1}},
		'{CMD_ON, 8'h38, 64'h0, 1'b1, 1'b0, NO_WRITE},
		'{CMD_OFF, 8'h05, 64'h0, 1'b1, 1'b1,
			'{OP_OFF, 2'd1, 4'd0, 8'h00, 3'd0, 1'b1}},
		'{CMD_OFF, 8'h07, 64'h0, 1'b1, 1'b0, NO_WRITE},
		'{CMD_CLEAR, 8'h06, 64'h0, 1'b1, 1'b1,
			'{OP_CLEAR, 2'd2, 4'd0, 8'h00, 3'd0, 1'b1}},
		'{CMD_CLEAR, 8'h02, 64'h0, 1'b1, 1'b0, NO_WRITE},
		// unused command kinds
		'{CMD_RSVD5, 8'h14, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_WRITE},
		'{CMD_RSVD6, 8'h3C, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_WRITE},
		'{CMD_RSVD7, 8'h06, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, NO_WRITE},
		// upper control bits set, mixed data
		'{CMD_WRITE, 8'hE4, 64'hA5A5_A5A5_5A5A_5A5A, 1'b0, 1'b0, NO_WRITE},
		'{CMD_WRITE, 8'hFC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_WRITE},
		// same write again: no change, no write
		'{CMD_WRITE, 8'hFC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, NO_WRITE},
		'{CMD_WRITE, 8'h00, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, NO_WRITE}
	};

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [2:0]  command    = '0;
	logic [7:0]  ctrl_byte  = '0;
	logic [63:0] data_bytes = '0;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [1:0]  op;
	logic [1:0]  board;
	logic [3:0]  address;
	logic [7:0]  value;
	logic [2:0]  level;
	logic        last;

	// Predictor state and expectations
	logic [7:0] shadow_mirror [MIRROR_DEPTH];
	drv_write_t fresh_writes [$];
	drv_write_t pending_writes [$];

	int send_idle_pct  = IDLE_PCT;
	int stall_pct      = IDLE_PCT;
	bit hold_request   = 1'b0;
	int error_count    = 0;
	int writes_checked = 0;
	int items_sent     = 0;
	int effective_items = 0;

	led_display_shadow_update i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.ctrl_byte  (ctrl_byte),
		.data_bytes (data_bytes),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.op         (op),
		.board      (board),
		.address    (address),
		.value      (value),
		.level      (level),
		.last       (last)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		foreach (shadow_mirror[i]) shadow_mirror[i] = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Predicts the driver writes of one transaction into fresh_writes
	function automatic void predict_driver_writes(logic [2:0] cmd, logic [7:0] ctrl,
			logic [63:0] data);
		int unsigned brd;
		int unsigned base;
		int unsigned start;
		int unsigned nbytes;
		int unsigned pos;
		logic [7:0] nb;
		logic [7:0] field;

		fresh_writes.delete();
		brd = 32'(ctrl[1:0]);
		case (cmd)
			CMD_WRITE: begin
				if (!ctrl[TYPE_POS]) begin
					// 4-digit board: always four bytes, shadow only
					if (brd < NUM_FOUR) begin
						for (int i = 0; i < 4; i++)
							shadow_mirror[4 * brd + i] = data[8 * i +: 8];
					end
				end else if (brd < NUM_EIGHT) begin
					nbytes = ctrl[SIZE_POS] ? 8 : 4;
					start  = (!ctrl[SIZE_POS] && ctrl[HALF_POS]) ? 4 : 0;
					base   = 4 * NUM_FOUR + 8 * brd;
					for (int i = 0; i < nbytes; i++) begin
						pos = start + i;
						nb  = data[8 * i +: 8];
						if (shadow_mirror[base + pos] != nb)
							fresh_writes.push_back('{OP_DATA, 2'(brd), 4'(2 * pos), nb,
								3'd0, 1'b0});
						shadow_mirror[base + pos] = nb;
					end
				end
			end
			CMD_LED: begin
				// no board type check: bit 2 belongs to the led number
				if (brd < NUM_EIGHT) begin
					field = (ctrl & LED_MASK) >> 2;
					fresh_writes.push_back('{OP_DATA, 2'(brd), {field[2:0], 1'b1},
						{7'd0, ctrl[LED_VAL_POS]}, 3'd0, 1'b0});
				end
			end
			CMD_ON: begin
				if (ctrl[TYPE_POS] && brd < NUM_EIGHT) begin
					field = (ctrl & LEVEL_MASK) >> 3;
					fresh_writes.push_back('{OP_ON, 2'(brd), 4'd0, 8'd0, field[2:0], 1'b0});
				end
			end
			CMD_OFF: begin
				if (ctrl[TYPE_POS] && brd < NUM_EIGHT)
					fresh_writes.push_back('{OP_OFF, 2'(brd), 4'd0, 8'd0, 3'd0, 1'b0});
			end
			CMD_CLEAR: begin
				if (ctrl[TYPE_POS] && brd < NUM_EIGHT)
					fresh_writes.push_back('{OP_CLEAR, 2'(brd), 4'd0, 8'd0, 3'd0, 1'b0});
			end
			default: begin
			end
		endcase
		if (fresh_writes.size() > 0) fresh_writes[fresh_writes.size() - 1].last = 1'b1;
	endfunction

	// Offers one transaction, waits for acceptance, then queues its expected writes
	task automatic issue(input logic [2:0] cmd, input logic [7:0] ctrl,
			input logic [63:0] data, input logic typed, input logic has_write,
			input drv_write_t typed_w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		ctrl_byte  <= ctrl;
		data_bytes <= data;
		do @(posedge clk); while (in_stall);
		items_sent++;
		predict_driver_writes(cmd, ctrl, data);
		if (fresh_writes.size() > 0 || (cmd == CMD_WRITE &&
				(!ctrl[TYPE_POS] || ctrl[1:0] < NUM_EIGHT)))
			effective_items++;
		if (typed) begin
			if (has_write) pending_writes.push_back(typed_w);
		end else begin
			foreach (fresh_writes[i]) pending_writes.push_back(fresh_writes[i]);
		end
	endtask

	// Sender pause until every expected write has arrived
	task automatic wait_all_written();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_writes.size() != 0) @(posedge clk);
	endtask

	// Output side: check accepted writes, then choose the next stall
	initial begin
		drv_write_t exp_w;
		drv_write_t got_w;
		int hold_left;

		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got_w = {op, board, address, value, level, last};
				if (pending_writes.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("unexpected driver write: op=%0d board=%0d",
							got_w.op, got_w.board,
							" addr=%0d value=%02h level=%0d last=%0d",
							got_w.address, got_w.value, got_w.level, got_w.last);
				end else begin
					exp_w = pending_writes.pop_front();
					writes_checked++;
					if (got_w !== exp_w) begin
						error_count++;
						if (error_count <= REPORT_LIMIT) begin
							$display("mismatch: expected op=%0d board=%0d",
								exp_w.op, exp_w.board,
								" addr=%0d value=%02h level=%0d last=%0d",
								exp_w.address, exp_w.value, exp_w.level, exp_w.last);
							$display("          got      op=%0d board=%0d",
								got_w.op, got_w.board,
								" addr=%0d value=%02h level=%0d last=%0d",
								got_w.address, got_w.value, got_w.level, got_w.last);
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Stimulus: directed table, then random transactions
	initial begin
		int k;
		int roll;
		int unsigned brd;
		int unsigned nbytes;
		int unsigned start;
		int unsigned base;
		bit keep_all;
		logic [2:0]  cmd;
		logic [7:0]  ctrl;
		logic [63:0] data;

		wait (arst_n === 1'b1);
		@(posedge clk);

		foreach (directed_rows[r])
			issue(directed_rows[r].cmd, directed_rows[r].ctrl, directed_rows[r].data,
				directed_rows[r].typed, directed_rows[r].has_write, directed_rows[r].typed_w);
		wait_all_written();

		k = 0;
		while (k < RANDOM_ITEMS - NUM_ROWS) begin
			// phases: output hold-off, drained pause, a stretch with no idling
			if (k == 100) hold_request = 1'b1;
			if (k == 200) wait_all_written();
			if (k == 250) begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			if (k == 350) begin
				send_idle_pct = IDLE_PCT;
				stall_pct = IDLE_PCT;
			end

			roll = $urandom_range(99);
			cmd  = CMD_WRITE;
			ctrl = 8'($urandom);
			data = {$urandom, $urandom};
			if (roll < 48) begin
				// 8-digit write, bytes partly copied from the shadow
				brd = $urandom_range(NUM_EIGHT - 1);
				ctrl[1:0] = 2'(brd);
				ctrl[TYPE_POS] = 1'b1;
				nbytes = ctrl[SIZE_POS] ? 8 : 4;
				start  = (!ctrl[SIZE_POS] && ctrl[HALF_POS]) ? 4 : 0;
				base   = 4 * NUM_FOUR + 8 * brd;
				keep_all = ($urandom_range(7) == 0);
				for (int i = 0; i < nbytes; i++)
					if (keep_all || $urandom_range(1))
						data[8 * i +: 8] = shadow_mirror[base + start + i];
			end else if (roll < 56) begin
				ctrl[TYPE_POS] = 1'b0;
			end else if (roll < 68) begin
				cmd = CMD_LED;
				ctrl[1:0] = 2'($urandom_range(NUM_EIGHT - 1));
			end else if (roll < 88) begin
				cmd = 3'($urandom_range(CMD_CLEAR, CMD_ON));
				ctrl[1:0] = 2'($urandom_range(NUM_EIGHT - 1));
				ctrl[TYPE_POS] = 1'b1;
			end else begin
				cmd = 3'($urandom_range(7));
			end
			issue(cmd, ctrl, data, 1'b0, 1'b0, NO_WRITE);
			k++;
		end

		wait_all_written();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run: %0d input transactions, %0d with an effect,",
			items_sent, effective_items, " %0d driver writes checked.", writes_checked);
		$display("Both board types, LED, on/off/clear, ignored kinds, hold-off, no-idle run.");
		if (error_count == 0 && pending_writes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d writes never seen", error_count, pending_writes.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("timeout: stimulus or expected writes did not complete");
		$display("*** FAILED ***");
		$finish;
	end

endmodule
